### src/icdv_pkg.sv
// shared constants, types and digit functions for the id check digit validator
`default_nettype none

package icdv_pkg;

	localparam int unsigned ID_W        = 30;
	localparam int unsigned DIGIT_W     = 4;
	localparam int unsigned CNT_W       = 4;
	localparam int unsigned PROD_W      = 62;
	localparam int unsigned RECIP_SHIFT = 35;
	localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
	localparam logic [DIGIT_W-1:0] RADIX      = 4'd10;
	localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;
	localparam logic [CNT_W-1:0]   MIN_DIGITS = 4'd8;
	localparam logic [CNT_W-1:0]   MAX_DIGITS = 4'd9;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
	} luhn_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0]   cnt;
		logic [DIGIT_W-1:0] sum;
	} luhn_stat_t;

	// doubled digit with digit-summing
	function automatic logic [DIGIT_W-1:0] luhn_double(input logic [DIGIT_W-1:0] d);
		logic [DIGIT_W:0] dd;
		dd = {d, 1'b0};
		if (dd > {1'b0, DIGIT_MAX}) begin
			return DIGIT_W'(dd - {1'b0, DIGIT_MAX});
		end
		return dd[DIGIT_W-1:0];
	endfunction

	// mod-ten add of two values each below ten
	function automatic logic [DIGIT_W-1:0] add_mod_ten(input logic [DIGIT_W-1:0] a,
		input logic [DIGIT_W-1:0] b);
		logic [DIGIT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, RADIX}) begin
			return DIGIT_W'(s - {1'b0, RADIX});
		end
		return s[DIGIT_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/icdv_digit_split.sv
// shift register that splits off one decimal digit per cycle while step is high
`default_nettype none

module icdv_digit_split (
	input  wire logic                          clk,
	input  wire logic                          load,
	input  wire logic [icdv_pkg::ID_W-1:0]     load_val,
	input  wire logic                          step,
	output logic [icdv_pkg::DIGIT_W-1:0]       digit,
	output logic                               is_zero
);

	logic [icdv_pkg::ID_W-1:0]   val_q;
	logic [icdv_pkg::PROD_W-1:0] prod;
	logic [icdv_pkg::ID_W-1:0]   quot;
	logic [icdv_pkg::ID_W-1:0]   quot_x10;
	logic [icdv_pkg::ID_W-1:0]   rem;

	// divide by ten through the reciprocal, exact for this range
	always_comb begin
		prod     = icdv_pkg::PROD_W'(val_q) * icdv_pkg::PROD_W'(icdv_pkg::RECIP_TEN);
		quot     = icdv_pkg::ID_W'(prod >> icdv_pkg::RECIP_SHIFT);
		quot_x10 = (quot << 3) + (quot << 1);
		rem      = val_q - quot_x10;
		digit    = rem[icdv_pkg::DIGIT_W-1:0];
		is_zero  = (val_q == '0);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else if (step) begin
			val_q <= quot;
		end
	end

endmodule

`default_nettype wire

### src/icdv_luhn_acc.sv
// digit counter and mod-ten luhn accumulator
`default_nettype none

module icdv_luhn_acc (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire icdv_pkg::luhn_ctrl_t          ctrl,
	input  wire logic [icdv_pkg::DIGIT_W-1:0]  digit,
	output icdv_pkg::luhn_stat_t               stat
);

	logic [icdv_pkg::CNT_W-1:0]   cnt_q;
	logic [icdv_pkg::DIGIT_W-1:0] sum_q;
	logic [icdv_pkg::DIGIT_W-1:0] term;

	// check digit sits at even position zero, odd positions are doubled
	always_comb begin
		term = cnt_q[0] ? icdv_pkg::luhn_double(digit) : digit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (ctrl.clear) begin
			cnt_q <= '0;
			sum_q <= '0;
		end else if (ctrl.step) begin
			cnt_q <= cnt_q + icdv_pkg::CNT_W'(1);
			sum_q <= icdv_pkg::add_mod_ten(sum_q, term);
		end
	end

	assign stat.cnt = cnt_q;
	assign stat.sum = sum_q;

endmodule

`default_nettype wire

### src/id_check_digit_validator.sv
// top level: luhn mod-ten check of an eight or nine digit identity number
`default_nettype none

// Takes one 30-bit binary identity number per word and returns one word with
// length_ok (eight or nine decimal digits) and valid_res (length ok and Luhn
// sum a multiple of ten). One decimal digit is split off per cycle by a
// reciprocal divide-by-ten in the digit shift register. When all decimal
// digits are split off (none for zero, at most ten), the result word is
// written to the output register, or the block waits in the hold state
// while that register is full and stalled, then returns to idle. One number
// is worked on at a time. A new number is taken as soon as the previous one
// is finished, even while its result still waits in the output register. The
// block keeps no state between numbers.
module id_check_digit_validator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      id_valid,
	output logic                           id_stall,
	input  wire logic [icdv_pkg::ID_W-1:0] id_number,
	output logic                           res_valid,
	input  wire logic                      res_stall,
	output logic                           length_ok,
	output logic                           valid_res
);

	icdv_pkg::state_t             state_q;
	icdv_pkg::state_t             state_nxt;
	icdv_pkg::luhn_ctrl_t         ctrl;
	icdv_pkg::luhn_stat_t         stat;
	logic [icdv_pkg::DIGIT_W-1:0] digit;
	logic                         is_zero;
	logic                         load;
	logic                         out_free;
	logic                         out_wr;
	logic                         len_ok;
	logic                         res_valid_q;
	logic                         length_ok_q;
	logic                         valid_res_q;

	icdv_digit_split u_split (
		.clk      (clk),
		.load     (load),
		.load_val (id_number),
		.step     (ctrl.step),
		.digit    (digit),
		.is_zero  (is_zero)
	);

	icdv_luhn_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.digit  (digit),
		.stat   (stat)
	);

	assign out_free = !res_valid_q || !res_stall;
	assign len_ok   = (stat.cnt == icdv_pkg::MIN_DIGITS) || (stat.cnt == icdv_pkg::MAX_DIGITS);

	always_comb begin
		state_nxt  = state_q;
		load       = 1'b0;
		ctrl.clear = 1'b0;
		ctrl.step  = 1'b0;
		out_wr     = 1'b0;
		id_stall   = 1'b1;
		unique case (state_q)
			icdv_pkg::ST_IDLE: begin
				id_stall = 1'b0;
				if (id_valid) begin
					load       = 1'b1;
					ctrl.clear = 1'b1;
					state_nxt  = icdv_pkg::ST_RUN;
				end
			end
			icdv_pkg::ST_RUN: begin
				if (!is_zero) begin
					ctrl.step = 1'b1;
				end else if (out_free) begin
					out_wr    = 1'b1;
					state_nxt = icdv_pkg::ST_IDLE;
				end else begin
					state_nxt = icdv_pkg::ST_HOLD;
				end
			end
			icdv_pkg::ST_HOLD: begin
				if (out_free) begin
					out_wr    = 1'b1;
					state_nxt = icdv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = icdv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= icdv_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (out_wr) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_wr) begin
			length_ok_q <= len_ok;
			valid_res_q <= len_ok && (stat.sum == '0);
		end
	end

	assign res_valid = res_valid_q;
	assign length_ok = length_ok_q;
	assign valid_res = valid_res_q;

endmodule

`default_nettype wire

### verif/id_check_digit_validator_tb.sv
// testbench for id_check_digit_validator: random and directed ids checked against a luhn predictor
`default_nettype none

module id_check_digit_validator_tb;
	import icdv_pkg::*;

	typedef struct {
		logic [ID_W-1:0] id;
		logic            length_ok;
		logic            valid_res;
	} verdict_t;

	class luhn_verdicts;
		verdict_t pending_verdicts[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
		endfunction

		function verdict_t luhn_verdict(input logic [ID_W-1:0] id);
			int unsigned v;
			int unsigned ndig;
			int unsigned total;
			int unsigned d;
			bit          dbl;
			verdict_t    r;
			r.id = id;
			v = id;
			ndig = 0;
			while (v != 0) begin
				v = v / 10;
				ndig++;
			end
			r.length_ok = (ndig >= MIN_DIGITS) && (ndig <= MAX_DIGITS);
			total = id % 10;
			v = id / 10;
			dbl = 1'b1;
			while (v != 0) begin
				d = v % 10;
				if (dbl) begin
					d = d * 2;
					if (d > 9) begin
						d = d - 9;
					end
				end
				total += d;
				dbl = !dbl;
				v = v / 10;
			end
			r.valid_res = r.length_ok && (total % 10 == 0);
			return r;
		endfunction

		function void note_id(input logic [ID_W-1:0] id);
			pending_verdicts.push_back(luhn_verdict(id));
		endfunction

		function void check_verdict(input logic lok, input logic vres);
			verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				$error("result word with no id pending: length_ok %0b valid_res %0b", lok, vres);
				mismatches++;
				return;
			end
			exp_v = pending_verdicts.pop_front();
			if (lok !== exp_v.length_ok) begin
				$error("id %0d length_ok: expected %0b, got %0b", exp_v.id, exp_v.length_ok, lok);
				mismatches++;
			end
			if (vres !== exp_v.valid_res) begin
				$error("id %0d valid_res: expected %0b, got %0b", exp_v.id, exp_v.valid_res, vres);
				mismatches++;
			end
		endfunction

		function int unsigned pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            id_valid;
	logic            id_stall;
	logic [ID_W-1:0] id_number;
	logic            res_valid;
	logic            res_stall;
	logic            length_ok;
	logic            valid_res;

	luhn_verdicts sb;
	int unsigned  results_seen;
	bit           tx_quiet;

	id_check_digit_validator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.id_valid  (id_valid),
		.id_stall  (id_stall),
		.id_number (id_number),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.length_ok (length_ok),
		.valid_res (valid_res)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#2000000;
		$display("id_check_digit_validator_tb: FAIL");
		$finish;
	end

	function automatic int unsigned pow10(input int unsigned n);
		int unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	// append the check digit that makes base pass the luhn test
	function automatic logic [ID_W-1:0] with_check_digit(input int unsigned base);
		verdict_t r;
		for (int unsigned c = 0; c < 10; c++) begin
			r = sb.luhn_verdict(ID_W'(base * 10 + c));
			if (r.valid_res) begin
				return ID_W'(base * 10 + c);
			end
		end
		return ID_W'(base * 10);
	endfunction

	function automatic logic [ID_W-1:0] random_id();
		int unsigned kind;
		int unsigned n;
		int unsigned p;
		kind = $urandom_range(0, 9);
		case (kind)
			0, 1, 2, 3: begin
				n = $urandom_range(7, 8);
				return with_check_digit($urandom_range(pow10(n - 1), pow10(n) - 1));
			end
			4, 5: begin
				return ID_W'($urandom_range(pow10(7), pow10(9) - 1));
			end
			6: begin
				return ID_W'($urandom);
			end
			7: begin
				n = $urandom_range(1, 7);
				return ID_W'($urandom_range(pow10(n - 1), pow10(n) - 1));
			end
			8: begin
				return ID_W'($urandom_range(pow10(9), (1 << ID_W) - 1));
			end
			default: begin
				p = pow10($urandom_range(7, 9));
				return ID_W'(p + $urandom_range(0, 6) - 3);
			end
		endcase
	endfunction

	task automatic offer_id(input logic [ID_W-1:0] v);
		int unsigned gap;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (tx_quiet || r < 55) begin
			gap = 0;
		end else if (r < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(8, 40);
		end
		if (gap > 0) begin
			@(negedge clk);
			id_valid <= 1'b0;
			id_number <= ID_W'($urandom);
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		id_valid <= 1'b1;
		id_number <= v;
		do @(posedge clk); while (id_stall);
		sb.note_id(v);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		id_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// result word monitor
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			sb.check_verdict(length_ok, valid_res);
			results_seen++;
		end
	end

	// receiver stall pattern, with one long hold-off
	initial begin
		int unsigned run;
		int unsigned r;
		bit          held;
		res_stall = 1'b0;
		run = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 500) begin
				held = 1'b1;
				res_stall <= 1'b1;
				repeat (300) @(negedge clk);
				res_stall <= 1'b0;
				run = 0;
			end else if (run > 0) begin
				run--;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5) begin
					res_stall <= 1'b0;
					run = $urandom_range(30, 80);
				end else if (r < 55) begin
					res_stall <= 1'b0;
					run = $urandom_range(0, 5);
				end else if (r < 90) begin
					res_stall <= 1'b1;
					run = $urandom_range(0, 2);
				end else begin
					res_stall <= 1'b1;
					run = $urandom_range(8, 40);
				end
			end
		end
	end

	initial begin
		logic [ID_W-1:0] directed_ids[$];
		sb = new();
		results_seen = 0;
		tx_quiet = 1'b0;
		arst_n = 1'b0;
		id_valid = 1'b0;
		id_number = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		directed_ids = '{
			ID_W'(0), ID_W'(1), ID_W'(9), ID_W'(10), ID_W'(1234567), ID_W'(9999999),
			ID_W'(10000000), ID_W'(10000001), ID_W'(99999999), ID_W'(100000000),
			ID_W'(999999999), ID_W'(1000000000), {ID_W{1'b1}},
			with_check_digit(1234567), with_check_digit(12345678),
			with_check_digit(9999999), with_check_digit(99999999),
			with_check_digit(1000000), with_check_digit(10000000),
			with_check_digit(1234567) ^ ID_W'(1), with_check_digit(99999999) ^ ID_W'(1),
			ID_W'(536870912), ID_W'(715827882)
		};
		foreach (directed_ids[k]) begin
			offer_id(directed_ids[k]);
		end

		for (int i = 0; i < 1730; i++) begin
			if ($urandom_range(0, 99) == 0) begin
				tx_quiet = !tx_quiet;
			end
			if (i == 900) begin
				pause_until_drained();
			end
			offer_id(random_id());
		end
		@(negedge clk);
		id_valid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("id_check_digit_validator_tb: PASS");
		end else begin
			$display("id_check_digit_validator_tb: FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire

### files.f
src/icdv_pkg.sv
src/icdv_digit_split.sv
src/icdv_luhn_acc.sv
src/id_check_digit_validator.sv
verif/id_check_digit_validator_tb.sv
